@@ src/set_all_table_macros.svh @@
// Assertion helpers for the set-all table.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef SET_ALL_TABLE_MACROS_SVH
`define SET_ALL_TABLE_MACROS_SVH

// Same-cycle implication.
`define SAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sat_pkg.sv @@
`timescale 1ns / 1ps

package sat_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 128;
    localparam int WORD_W              = 32;
    localparam int STAMP_W             = 32;
    localparam int INDEX_W             = 8;
    localparam int MODE_W              = 2;

    localparam logic [STAMP_W-1:0] STAMP_MAX   = '1;
    localparam logic [STAMP_W-1:0] STAMP_RESET = STAMP_W'(1);
    localparam logic [WORD_W-1:0]  READ_OOR    = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET     = 2'd0,
        MODE_GET     = 2'd1,
        MODE_SET_ALL = 2'd2
    } mode_t;

    // One memory word: entry value in the upper half, write stamp in the lower half.
    typedef struct packed {
        logic [WORD_W-1:0]  value;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // Facts about a get that are registered alongside the memory read.
    typedef struct packed {
        logic oor;
        logic entry_valid;
    } get_ctl_t;

endpackage

@@ src/sat_req_if.sv @@
`timescale 1ns / 1ps

interface sat_req_if
    import sat_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [INDEX_W-1:0]        index;
    logic signed [WORD_W-1:0]  value;

    modport source (output valid, output mode, output index, output value, input ready);
    modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

@@ src/sat_rsp_if.sv @@
`timescale 1ns / 1ps

interface sat_rsp_if
    import sat_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [WORD_W-1:0]  read_value;
    logic                      out_of_range;

    modport source (output valid, output read_value, output out_of_range, input ready);
    modport sink   (input valid, input read_value, input out_of_range, output ready);
endinterface

@@ src/sat_mem.sv @@
`timescale 1ns / 1ps

// Single-port synchronous RAM, read data registered.
module sat_mem
    import sat_pkg::*;
#(
    parameter int DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int WIDTH = WORD_W + STAMP_W
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/set_all_table.sv @@
`timescale 1ns / 1ps

// Set-all table: TABLE_DEPTH signed 32-bit entries with a constant-time "set every entry".
// Each request transaction carries a mode: set writes one entry and stamps it with the
// write counter, set-all records a global value and stamp, get returns the entry value
// or the global value when the entry stamp is strictly older than the set-all stamp.
// Only get produces a response transaction; an out-of-range get answers -1 with
// out_of_range set, an out-of-range set and the unused mode are dropped. The write
// counter starts at one and saturates at its maximum. Entries live in one single-port
// RAM holding {value, stamp}; a per-entry valid bit cleared at reset makes unwritten
// entries read as zero, so no clearing pass runs after reset. A get reads the RAM in
// the cycle it is accepted; its response loads into the output register from the
// registered RAM word once that register is free, and the next request is taken in
// that same cycle, giving one transaction per cycle as long as the response side keeps
// draining. While the response side stalls, one more get waits behind the output
// register, and the request side then stalls until it moves.
module set_all_table
    import sat_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    sat_req_if.sink     req,
    sat_rsp_if.source   rsp
);

`include "set_all_table_macros.svh"

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam logic [INDEX_W:0] DEPTH_LIM = (INDEX_W + 1)'(TABLE_DEPTH);

    // Request decode
    mode_t             req_mode;
    logic              is_set;
    logic              is_get;
    logic              is_all;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic              req_fire;
    logic              take_stamp;

    // State
    logic [STAMP_W-1:0]     counter_reg;
    logic [STAMP_W-1:0]     counter_next;
    logic [WORD_W-1:0]      global_value_reg;
    logic [STAMP_W-1:0]     global_stamp_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   pend_reg;
    get_ctl_t               ctl_reg;

    // RAM
    entry_t mem_wdata;
    entry_t mem_rdata;
    logic   mem_en;

    // Resolution and output register
    logic [WORD_W-1:0]  entry_value;
    logic [STAMP_W-1:0] entry_stamp;
    logic [WORD_W-1:0]  result;
    logic               out_load;
    logic               rsp_valid_reg;
    logic [WORD_W-1:0]  read_value_reg;
    logic               oor_reg;

    assign req_mode = mode_t'(req.mode);

    always_comb
    begin
        is_set = 1'b0;
        is_get = 1'b0;
        is_all = 1'b0;
        unique case (req_mode)
            MODE_SET:     is_set = 1'b1;
            MODE_GET:     is_get = 1'b1;
            MODE_SET_ALL: is_all = 1'b1;
            default:      ; // unused code: drop the transaction
        endcase
    end

    assign in_range   = {1'b0, req.index} < DEPTH_LIM;
    assign addr       = req.index[ADDR_W-1:0];

    // A pending get frees its slot in the cycle it moves to the output register,
    // so the next request can enter in that same cycle.
    assign out_load   = pend_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready  = !pend_reg || out_load;
    assign req_fire   = req.valid && req.ready;
    assign take_stamp = req_fire && ((is_set && in_range) || is_all);

    // Saturating write counter
    assign counter_next = (counter_reg == STAMP_MAX) ? counter_reg : counter_reg + 1'b1;

    // RAM access: write on set, read on get, never both in one cycle.
    assign mem_en          = req_fire && in_range && (is_set || is_get);
    assign mem_wdata.value = req.value;
    assign mem_wdata.stamp = counter_reg;

    sat_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WORD_W + STAMP_W)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (is_set),
        .addr  (addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg      <= STAMP_RESET;
            global_value_reg <= '0;
            global_stamp_reg <= '0;
            valid_reg        <= '0;
            pend_reg         <= 1'b0;
            ctl_reg          <= '0;
        end
        else
        begin
            if (take_stamp)
            begin
                counter_reg <= counter_next;
            end
            if (req_fire && is_all)
            begin
                global_value_reg <= req.value;
                global_stamp_reg <= counter_reg;
            end
            if (req_fire && is_set && in_range)
            begin
                valid_reg[addr] <= 1'b1;
            end
            // Capture what the get needs besides the RAM word; a new get wins
            // over the retirement of the old one.
            if (req_fire && is_get)
            begin
                pend_reg            <= 1'b1;
                ctl_reg.oor         <= !in_range;
                ctl_reg.entry_valid <= valid_reg[addr];
            end
            else if (out_load)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    // Unwritten entries read as zero value with zero stamp.
    assign entry_value = ctl_reg.entry_valid ? mem_rdata.value : '0;
    assign entry_stamp = ctl_reg.entry_valid ? mem_rdata.stamp : '0;

    always_comb
    begin
        priority if (ctl_reg.oor)
        begin
            result = READ_OOR;
        end
        else if (entry_stamp < global_stamp_reg)
        begin
            result = global_value_reg;
        end
        else
        begin
            result = entry_value;
        end
    end

    // Output register: load a resolved get, hold while the sink stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            read_value_reg <= '0;
            oor_reg        <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg  <= 1'b1;
            read_value_reg <= result;
            oor_reg        <= ctl_reg.oor;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.read_value   = read_value_reg;
    assign rsp.out_of_range = oor_reg;

    // Checks
    `SAT_ASSERT_NEXT(a_get_pends, req_fire && is_get, pend_reg,
        "accepted get did not become pending")
    `SAT_ASSERT_NEXT(a_pend_holds, pend_reg && rsp_valid_reg && !rsp.ready,
        pend_reg && rsp_valid_reg,
        "pending get lost while response stalled")
    `SAT_ASSERT_NEXT(a_stamp_step, take_stamp && counter_reg != STAMP_MAX,
        counter_reg == $past(counter_reg) + 1'b1,
        "write counter did not advance on a write")
    `SAT_ASSERT_NOW(a_oor_value, rsp.valid && rsp.out_of_range, rsp.read_value == READ_OOR,
        "out-of-range response without all-ones value")

endmodule
